@@ hdl/dtfd_pkg.sv @@
// Package: shared constants and types for the double to decimal text converter.
`timescale 1ns / 1ps
package dtfd_pkg;
   localparam int INT_DIGITS  = 10;
   localparam int FRAC_DIGITS = 16;
   localparam int DEF_PREC    = 6;
   localparam int BUF_LEN     = INT_DIGITS + FRAC_DIGITS + 2;
   localparam int BUF_AW      = $clog2(BUF_LEN);
   localparam logic [63:0] INT_LIMIT = 64'h0000_0000_FFFF_FFFF;

   localparam logic [1:0] ST_NUMBER = 2'd0;
   localparam logic [1:0] ST_INF    = 2'd1;
   localparam logic [1:0] ST_NAN    = 2'd2;
   localparam logic [1:0] ST_BIG    = 2'd3;

   localparam logic [1:0] SIGN_NONE  = 2'd0;
   localparam logic [1:0] SIGN_MINUS = 2'd3;

   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_DOT  = 8'h2E;
   localparam logic [7:0] CH_ONE  = 8'h31;

   // one step of the shared times-ten unit
   typedef struct packed {
      logic [63:0] acc;
      logic [3:0]  digit;
   } ten_out_type;
endpackage

@@ hdl/dtfd_ten.sv @@
// Shared unit: multiplies a Q0.64 accumulator by ten, returns carry digit.
`timescale 1ns / 1ps
module dtfd_ten (
   input  logic [63:0]               acc,
   output dtfd_pkg::ten_out_type     res
);
   logic [67:0] prod;
   assign prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
   assign res.acc = prod[63:0];
   assign res.digit = prod[67:64];
endmodule

@@ hdl/double_to_fixed_decimal_text.sv @@
// Top level: converts a binary64 value to printf %f body text, one character per response.
//  channel | ports  | tdata bits                                   | tuser
//  request | req_*  | [63:0] value_bits [71:64] precision [72] alt_flag [74:73] sign_mode | -
//  result  | rsp_*  | [7:0] text_char [9:8] sign_code [16:10] pad_zeros [18:17] status | tlast is_last
// Steps: an accept step, a divide step per integer digit (up to 10 digits), then a copy step
// per digit, the point, one step per fraction digit through the shared times-ten unit (up to 16
// digits), a look-ahead step, a read and check pair per buffer position for the carry or
// negative-zero scan, a read setup step, then one character per cycle while rsp_tready is high.
// Reset clears the sequencer and the accumulator; buffer contents are undefined until written.
// A stalled rsp_tready holds the current character; req_tready is low until the run ends.
`timescale 1ns / 1ps
module double_to_fixed_decimal_text (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // value_bits, precision, alt_flag, sign_mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // text_char, sign_code, pad_zeros, status
   output logic        rsp_tlast
);
   localparam logic [3:0] S_IDLE = 4'd0, S_INT = 4'd1, S_IWR = 4'd2, S_DOT = 4'd3,
      S_FRAC = 4'd4, S_LOOK = 4'd5, S_CRD = 4'd6, S_CRW = 4'd7, S_ZRD = 4'd8,
      S_ZCK = 4'd9, S_OUTR = 4'd10, S_OUT = 4'd11;
   localparam int AW = dtfd_pkg::BUF_AW;

   logic [3:0]  state_ff, state_in;
   logic [63:0] acc_ff, acc_in;        // fraction accumulator
   logic [31:0] ipart_ff, ipart_in;
   logic        sticky_ff, sticky_in;
   logic        alt_ff, alt_in;
   logic [1:0]  sm_ff, sm_in, sign_ff, sign_in, status_ff, status_in;
   logic [4:0]  p_ff, p_in;
   logic [6:0]  extra_ff, extra_in;
   logic [AW-1:0] len_ff, len_in, idx_ff, idx_in, start_ff, start_in;
   logic [7:0]  tmp_ff [0:9];
   logic [7:0]  tmp_in [0:9];
   logic [3:0]  nd_ff, nd_in;
   logic        allz_ff, allz_in;

   logic [7:0]  mem [0:dtfd_pkg::BUF_LEN-1];
   logic        we;
   logic [AW-1:0] waddr, raddr;
   logic [7:0]  wdata, rdata_ff;

   dtfd_pkg::ten_out_type ten;
   dtfd_ten u_ten (.acc(acc_ff), .res(ten));

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   // decode of input
   logic [63:0] bits;
   logic [10:0] ef;
   logic [51:0] man;
   logic [52:0] mant;
   logic [11:0] n;
   logic [63:0] fa0, ip0, f0;
   logic        st0, big0;
   logic signed [7:0] prec;
   assign bits = req_tdata[63:0];
   assign prec = req_tdata[71:64];
   assign ef = bits[62:52];
   assign man = bits[51:0];
   assign mant = (ef != 11'd0) ? {1'b1, man} : {1'b0, man};
   assign n = (ef != 11'd0) ? 12'd1075 - {1'b0, ef} : 12'd1074;

   always_comb begin
      ip0 = '0; f0 = '0; fa0 = '0; st0 = 1'b0; big0 = 1'b0;
      if (ef >= 11'd1075) begin
         big0 = mant != '0;
      end else begin
         ip0 = (n < 12'd64) ? ({11'd0, mant} >> n[5:0]) : 64'd0;
         f0 = (n < 12'd64) ? ({11'd0, mant} & ((64'd1 << n[5:0]) - 64'd1)) : {11'd0, mant};
         if (n <= 12'd64) fa0 = (n == 12'd64) ? f0 : f0 << (7'd64 - n[6:0]);
         else if (n < 12'd128) begin
            fa0 = f0 >> (n[5:0]);
            st0 = (f0 & ((64'd1 << n[5:0]) - 64'd1)) != 64'd0;
         end else st0 = f0 != 64'd0;
         if (ip0 > dtfd_pkg::INT_LIMIT) big0 = 1'b1;
      end
   end

   logic [7:0] cur_ch;
   always_comb begin
      unique case (status_ff)
         dtfd_pkg::ST_INF: cur_ch = (idx_ff == 0) ? 8'h49 : (idx_ff == 1) ? 8'h6E : 8'h66;
         dtfd_pkg::ST_NAN: cur_ch = (idx_ff == 1) ? 8'h61 : 8'h4E;
         dtfd_pkg::ST_BIG: begin
            unique case (idx_ff)
               0: cur_ch = 8'h54;
               1, 2: cur_ch = 8'h6F;
               3: cur_ch = 8'h62;
               4: cur_ch = 8'h69;
               default: cur_ch = 8'h67;
            endcase
         end
         default: cur_ch = rdata_ff;
      endcase
   end

   // divide by ten through a reciprocal multiply, exact for 32-bit operands
   logic [63:0] recip;
   logic [31:0] iq;
   logic [3:0]  ir;
   assign recip = {32'd0, ipart_ff} * 64'h0000_0000_CCCC_CCCD;
   assign iq = {3'd0, recip[63:35]};
   assign ir = 4'(ipart_ff - ((iq << 3) + (iq << 1)));

   always_comb begin
      state_in = state_ff; acc_in = acc_ff; ipart_in = ipart_ff; sticky_in = sticky_ff;
      alt_in = alt_ff; sm_in = sm_ff; sign_in = sign_ff; status_in = status_ff;
      p_in = p_ff; extra_in = extra_ff; len_in = len_ff; idx_in = idx_ff;
      start_in = start_ff; tmp_in = tmp_ff; nd_in = nd_ff; allz_in = allz_ff;
      we = 1'b0; waddr = idx_ff; wdata = '0; raddr = idx_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) begin
            sm_in = (req_tdata[74:73] == 2'd3) ? dtfd_pkg::SIGN_NONE : req_tdata[74:73];
            sign_in = sm_in; alt_in = req_tdata[72];
            acc_in = fa0; sticky_in = st0; ipart_in = ip0[31:0];
            nd_in = '0; idx_in = '0; extra_in = '0; start_in = AW'(1);
            if (prec < 0) p_in = 5'(dtfd_pkg::DEF_PREC);
            else if (prec > 8'(dtfd_pkg::FRAC_DIGITS)) begin
               p_in = 5'(dtfd_pkg::FRAC_DIGITS);
               extra_in = 7'(prec - 8'(dtfd_pkg::FRAC_DIGITS));
            end else p_in = prec[4:0];
            if (ef == 11'h7FF) begin
               start_in = '0;
               if (man == '0) begin
                  status_in = dtfd_pkg::ST_INF;
                  if (bits[63]) sign_in = dtfd_pkg::SIGN_MINUS;
               end else status_in = dtfd_pkg::ST_NAN;
               len_in = AW'(3); state_in = S_OUT;
               p_in = '0; extra_in = '0;
            end else begin
               status_in = dtfd_pkg::ST_NUMBER;
               if (bits[63] && mant != '0) sign_in = dtfd_pkg::SIGN_MINUS;
               if (big0) begin
                  status_in = dtfd_pkg::ST_BIG; start_in = '0; len_in = AW'(6);
                  p_in = '0; extra_in = '0; state_in = S_OUT;
               end else state_in = S_INT;
            end
         end
         S_INT: begin
            tmp_in[nd_ff] = dtfd_pkg::CH_ZERO + {4'd0, ir};
            nd_in = nd_ff + 4'd1; ipart_in = iq;
            if (iq == 32'd0) begin
               len_in = AW'(1); idx_in = AW'(nd_ff); state_in = S_IWR;
            end
         end
         S_IWR: begin
            we = 1'b1; waddr = len_ff; wdata = tmp_ff[idx_ff[3:0]];
            len_in = len_ff + AW'(1); idx_in = idx_ff - AW'(1);
            if (idx_ff == '0) state_in = S_DOT;
         end
         S_DOT: begin
            if (p_ff != '0 || alt_ff) begin
               we = 1'b1; waddr = len_ff; wdata = dtfd_pkg::CH_DOT; len_in = len_ff + AW'(1);
            end
            if ((acc_ff != '0 || sticky_ff) && p_ff != '0) state_in = S_FRAC;
            else if (acc_ff != '0 || sticky_ff) state_in = S_LOOK;
            else state_in = S_OUTR;
         end
         S_FRAC: begin
            we = 1'b1; waddr = len_ff; wdata = dtfd_pkg::CH_ZERO + {4'd0, ten.digit};
            len_in = len_ff + AW'(1); acc_in = ten.acc; p_in = p_ff - 5'd1;
            if (p_ff == 5'd1 || (ten.acc == '0 && !sticky_ff))
               state_in = (ten.acc != '0 || sticky_ff) ? S_LOOK : S_OUTR;
         end
         S_LOOK: begin
            idx_in = len_ff - AW'(1); raddr = len_ff - AW'(1);
            allz_in = 1'b1;
            if (ten.digit > 4'd4) state_in = S_CRD;
            else if (sign_ff == dtfd_pkg::SIGN_MINUS) begin
               idx_in = AW'(1); raddr = AW'(1); state_in = S_ZRD;
            end else state_in = S_OUTR;
         end
         S_CRD: state_in = S_CRW;   // read latency
         S_CRW: begin
            if (idx_ff == '0) begin
               we = 1'b1; waddr = '0; wdata = dtfd_pkg::CH_ONE; start_in = '0;
               state_in = S_OUTR;
            end else if (rdata_ff == dtfd_pkg::CH_DOT) begin
               idx_in = idx_ff - AW'(1); raddr = idx_in; state_in = S_CRD;
            end else if (rdata_ff == dtfd_pkg::CH_NINE) begin
               we = 1'b1; wdata = dtfd_pkg::CH_ZERO;
               idx_in = idx_ff - AW'(1); raddr = idx_in; state_in = S_CRD;
            end else begin
               we = 1'b1; wdata = rdata_ff + 8'd1; state_in = S_OUTR;
            end
         end
         S_ZRD: state_in = S_ZCK;
         S_ZCK: begin
            if (rdata_ff != dtfd_pkg::CH_DOT && rdata_ff != dtfd_pkg::CH_ZERO) allz_in = 1'b0;
            if (idx_ff == len_ff - AW'(1)) begin
               if (allz_in) sign_in = sm_ff;
               state_in = S_OUTR;
            end else begin
               idx_in = idx_ff + AW'(1); raddr = idx_in; state_in = S_ZRD;
            end
         end
         S_OUTR: begin
            idx_in = start_ff; raddr = start_ff; state_in = S_OUT;
         end
         S_OUT: begin
            raddr = idx_ff;
            if (rsp_tready) begin
               idx_in = idx_ff + AW'(1); raddr = idx_in;
               if (idx_ff == len_ff - AW'(1)) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         acc_ff <= '0;
      end else begin
         state_ff <= state_in;
         acc_ff <= acc_in;
      end
      ipart_ff <= ipart_in; sticky_ff <= sticky_in; alt_ff <= alt_in;
      sm_ff <= sm_in; sign_ff <= sign_in; status_ff <= status_in; p_ff <= p_in;
      extra_ff <= extra_in; len_ff <= len_in; idx_ff <= idx_in; start_ff <= start_in;
      tmp_ff <= tmp_in; nd_ff <= nd_in; allz_ff <= allz_in;
   end

   logic [6:0] pad;
   assign pad = 7'({2'b00, p_ff} + extra_ff);
   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = state_ff == S_OUT;
   assign rsp_tlast = idx_ff == len_ff - AW'(1);
   assign rsp_tdata = {5'd0, status_ff, pad, sign_ff, cur_ch};

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("ready while emitting");
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> len_ff > start_ff) else $error("empty run");
   a_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> idx_ff < len_ff) else $error("index past run");
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready) else $error("no return to idle");
endmodule
